[rtl/core/tcpq_pkg.sv]
package tcpq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int ID_BITS_DEF  = 16;

    localparam int VID_W  = 16;
    localparam int CLS_W  = 2;
    localparam int OCC_W  = 5;

    localparam logic [CLS_W-1:0] CLASS_FIRST = 2'd1;
    localparam logic [CLS_W-1:0] CLASS_LAST  = 2'd3;

    typedef enum logic {
        CMD_INSERT  = 1'b0,
        CMD_RELEASE = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_BADCLASS = 2'd3
    } t_status;

    // Broadcast from the controller to every cell of the chain.
    typedef struct packed {
        logic             ins;
        logic             rel;
        logic [CLS_W-1:0] cls;
    } t_cell_ctl;

endpackage

[rtl/core/tcpq_if.sv]
interface tcpq_cmd_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [15:0] vehicle_id;
    logic [1:0]  vehicle_class;

    modport source (output valid, output cmd, output vehicle_id, output vehicle_class,
                    input ready);
    modport sink   (input valid, input cmd, input vehicle_id, input vehicle_class,
                    output ready);
endinterface

interface tcpq_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] released_id;
    logic [1:0]  released_class;
    logic [4:0]  occupancy;

    modport source (output valid, output status, output released_id,
                    output released_class, output occupancy, input ready);
    modport sink   (input valid, input status, input released_id,
                    input released_class, input occupancy, output ready);
endinterface

[rtl/core/tcpq_cell.sv]
module tcpq_cell #(
    parameter int ID_BITS = tcpq_pkg::ID_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tcpq_pkg::t_cell_ctl   i_ctl,
    input  logic [ID_BITS-1:0]    i_new_id,
    input  logic                  i_left_valid,
    input  logic                  i_left_ga,
    input  logic [ID_BITS-1:0]    i_left_id,
    input  logic [1:0]            i_left_cls,
    input  logic                  i_right_valid,
    input  logic [ID_BITS-1:0]    i_right_id,
    input  logic [1:0]            i_right_cls,
    output logic                  o_valid,
    output logic [ID_BITS-1:0]    o_id,
    output logic [1:0]            o_cls,
    output logic                  o_ga
);
    import tcpq_pkg::*;

    logic               r_valid, n_valid;
    logic [ID_BITS-1:0] r_id, n_id;
    logic [CLS_W-1:0]   r_cls, n_cls;
    logic               w_ga;

    // Entry has lower priority than the one being inserted: it moves back.
    assign w_ga = r_valid && (r_cls > i_ctl.cls);

    always_comb begin
        n_valid = r_valid;
        n_id    = r_id;
        n_cls   = r_cls;
        if (i_ctl.ins) begin
            if (i_left_ga) begin
                n_valid = 1'b1;
                n_id    = i_left_id;
                n_cls   = i_left_cls;
            end else if (i_left_valid && (w_ga || !r_valid)) begin
                n_valid = 1'b1;
                n_id    = i_new_id;
                n_cls   = i_ctl.cls;
            end
        end else if (i_ctl.rel) begin
            n_valid = i_right_valid;
            n_id    = i_right_id;
            n_cls   = i_right_cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_id  <= n_id;
        r_cls <= n_cls;
    end

    assign o_valid = r_valid;
    assign o_id    = r_id;
    assign o_cls   = r_cls;
    assign o_ga    = w_ga;

endmodule

[rtl/core/three_class_priority_queue_top.sv]
// Three-class strict priority queue (emergency, public transport, private).
// Command channel i_cmd: cmd 0 inserts vehicle_id with vehicle_class,
// cmd 1 releases the head entry. Every command transaction gives exactly
// one transaction on o_res: status, released id and class, and occupancy.
// Entries are held in a chain of cells kept sorted by class; an insert
// shifts the lower-priority tail back by one cell, and a release shifts the
// whole chain forward by one cell.
// The result is registered and is on o_res in the cycle after the command is taken.
// Throughput: one command per cycle while o_res is taken every cycle; the
// chain is updated at the edge that takes a command, so the next command sees the new order.
// A single output register holds the result; when o_res stalls, i_cmd
// ready stays high only while that register is empty or is being emptied in the same
// cycle, so at most one result waits and nothing is dropped.
// Reset (i_rst_n low, synchronous) empties the queue and the output
// register; stored identifiers are not cleared.
// Status: ok, release on empty queue, queue full, invalid class (class 0).
module three_class_priority_queue_top #(
    parameter int CAPACITY = tcpq_pkg::CAPACITY_DEF,
    parameter int ID_BITS  = tcpq_pkg::ID_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tcpq_cmd_if.sink   i_cmd,
    tcpq_res_if.source o_res
);
    import tcpq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]     r_count, n_count;
    logic                 r_res_valid;
    t_status              r_status, n_status;
    logic [VID_W-1:0]     r_rid, n_rid;
    logic [CLS_W-1:0]     r_rcls, n_rcls;
    logic [OCC_W-1:0]     r_occ;

    logic                 w_accept;
    logic                 w_bad_cls;
    logic                 w_full;
    logic [ID_BITS-1:0]   w_new_id;
    logic [ID_BITS+VID_W-1:0] w_id_in_ext, w_id_out_ext;
    logic [CNT_W+OCC_W-1:0]   w_occ_ext;
    t_cell_ctl            w_ctl;

    logic                 w_valid [CAPACITY];
    logic [ID_BITS-1:0]   w_id    [CAPACITY];
    logic [CLS_W-1:0]     w_cls   [CAPACITY];
    logic                 w_ga    [CAPACITY];

    assign i_cmd.ready = !r_res_valid || o_res.ready;
    assign w_accept    = i_cmd.valid && i_cmd.ready;

    assign w_id_in_ext = {{ID_BITS{1'b0}}, i_cmd.vehicle_id};
    assign w_new_id    = w_id_in_ext[ID_BITS-1:0];
    assign w_id_out_ext = {{VID_W{1'b0}}, w_id[0]};

    assign w_bad_cls = (i_cmd.vehicle_class < CLASS_FIRST) ||
                       (i_cmd.vehicle_class > CLASS_LAST);
    assign w_full    = (r_count == CNT_W'(CAPACITY));

    always_comb begin
        n_status  = ST_OK;
        n_rid     = '0;
        n_rcls    = '0;
        n_count   = r_count;
        w_ctl.ins = 1'b0;
        w_ctl.rel = 1'b0;
        w_ctl.cls = i_cmd.vehicle_class;
        if (i_cmd.cmd == CMD_INSERT) begin
            if (w_bad_cls) begin
                n_status = ST_BADCLASS;
            end else if (w_full) begin
                n_status = ST_FULL;
            end else begin
                w_ctl.ins = w_accept;
                n_count   = r_count + CNT_W'(1);
            end
        end else begin
            if (r_count == '0) begin
                n_status = ST_EMPTY;
            end else begin
                w_ctl.rel = w_accept;
                n_rid     = w_id_out_ext[VID_W-1:0];
                n_rcls    = w_cls[0];
                n_count   = r_count - CNT_W'(1);
            end
        end
    end

    assign w_occ_ext = {{OCC_W{1'b0}}, n_count};

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic               left_valid, left_ga, right_valid;
            logic [ID_BITS-1:0] left_id, right_id;
            logic [CLS_W-1:0]   left_cls, right_cls;

            if (g == 0) begin : g_head
                assign left_valid = 1'b1;
                assign left_ga    = 1'b0;
                assign left_id    = '0;
                assign left_cls   = '0;
            end else begin : g_body
                assign left_valid = w_valid[g-1];
                assign left_ga    = w_ga[g-1];
                assign left_id    = w_id[g-1];
                assign left_cls   = w_cls[g-1];
            end

            if (g == CAPACITY - 1) begin : g_tail
                assign right_valid = 1'b0;
                assign right_id    = '0;
                assign right_cls   = '0;
            end else begin : g_next
                assign right_valid = w_valid[g+1];
                assign right_id    = w_id[g+1];
                assign right_cls   = w_cls[g+1];
            end

            tcpq_cell #(
                .ID_BITS (ID_BITS)
            ) u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctl         (w_ctl),
                .i_new_id      (w_new_id),
                .i_left_valid  (left_valid),
                .i_left_ga     (left_ga),
                .i_left_id     (left_id),
                .i_left_cls    (left_cls),
                .i_right_valid (right_valid),
                .i_right_id    (right_id),
                .i_right_cls   (right_cls),
                .o_valid       (w_valid[g]),
                .o_id          (w_id[g]),
                .o_cls         (w_cls[g]),
                .o_ga          (w_ga[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_res_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_res_valid <= 1'b0;
            end
        end
        if (w_accept) begin
            r_status <= n_status;
            r_rid    <= n_rid;
            r_rcls   <= n_rcls;
            r_occ    <= w_occ_ext[OCC_W-1:0];
        end
    end

    assign o_res.valid          = r_res_valid;
    assign o_res.status         = r_status;
    assign o_res.released_id    = r_rid;
    assign o_res.released_class = r_rcls;
    assign o_res.occupancy      = r_occ;

endmodule

[tb/tb_top.sv]
module tb_top;
    import tcpq_pkg::*;

    localparam int CAP         = CAPACITY_DEF;
    localparam int RAND_ITEMS  = 1250;
    localparam int LONG_HOLD   = 200;
    localparam int DRAIN_LIMIT = 5000;

    localparam logic [CLS_W-1:0] CLS_NONE    = 2'd0;
    localparam logic [CLS_W-1:0] CLS_EMERG   = 2'd1;
    localparam logic [CLS_W-1:0] CLS_PUBLIC  = 2'd2;
    localparam logic [CLS_W-1:0] CLS_PRIVATE = 2'd3;

    typedef struct packed {
        logic [VID_W-1:0] id;
        logic [CLS_W-1:0] cls;
    } t_vehicle;

    typedef struct packed {
        t_status          status;
        logic [VID_W-1:0] rid;
        logic [CLS_W-1:0] rcls;
        logic [OCC_W-1:0] occ;
    } t_outcome;

    typedef struct {
        t_cmd             c;
        logic [VID_W-1:0] id;
        logic [CLS_W-1:0] cls;
        int               reps;
        bit               typed;
        t_outcome         want;
    } t_row;

    localparam t_outcome NO_OUTCOME = '0;

    logic i_clk;
    logic i_rst_n;

    tcpq_cmd_if cmd_if ();
    tcpq_res_if res_if ();

    three_class_priority_queue_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    t_vehicle waiting_q[$];   // predicted queue contents, head first
    t_outcome outcome_q[$];   // expected results, oldest first
    t_row     dir_rows[$];

    int  errors;
    int  n_cmds;
    int  n_checked;
    int  n_ins_ok;
    int  n_rel_ok;
    int  peak_occ;
    int  status_tally[4];
    bit  tx_eager;
    bit  rx_eager;
    bit  hold_req;

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH result %0d %s: got %0h, expected %0h", n_checked, what, got, want);
        errors++;
    endtask

    function automatic t_outcome apply_command(input t_cmd c, input logic [VID_W-1:0] id,
                                               input logic [CLS_W-1:0] cls);
        t_outcome o;
        int       pos;
        o = NO_OUTCOME;
        o.status = ST_OK;
        if (c == CMD_INSERT) begin
            // class check takes precedence over the full check
            if (cls < CLASS_FIRST || cls > CLASS_LAST) begin
                o.status = ST_BADCLASS;
            end else if (waiting_q.size() >= CAP) begin
                o.status = ST_FULL;
            end else begin
                pos = 0;
                while (pos < waiting_q.size() && waiting_q[pos].cls <= cls) pos++;
                waiting_q.insert(pos, '{id: id, cls: cls});
                n_ins_ok++;
            end
        end else if (waiting_q.size() == 0) begin
            o.status = ST_EMPTY;
        end else begin
            o.rid  = waiting_q[0].id;
            o.rcls = waiting_q[0].cls;
            void'(waiting_q.pop_front());
            n_rel_ok++;
        end
        o.occ = OCC_W'(waiting_q.size());
        if (waiting_q.size() > peak_occ) peak_occ = waiting_q.size();
        status_tally[o.status]++;
        return o;
    endfunction

    function automatic int pick_gap();
        int r;
        if (tx_eager) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    task automatic issue(input t_cmd c, input logic [VID_W-1:0] id, input logic [CLS_W-1:0] cls,
                         input bit typed, input t_outcome want);
        t_outcome pred;
        int       gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            cmd_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        cmd_if.valid         <= 1'b1;
        cmd_if.cmd           <= c;
        cmd_if.vehicle_id    <= id;
        cmd_if.vehicle_class <= cls;
        do @(posedge i_clk); while (!(cmd_if.valid && cmd_if.ready));
        pred = apply_command(c, id, cls);
        outcome_q.push_back(typed ? want : pred);
        n_cmds++;
    endtask

    task automatic wait_drained();
        int n;
        n = 0;
        while (outcome_q.size() != 0 && n < DRAIN_LIMIT) begin
            @(posedge i_clk);
            n++;
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (outcome_q.size() == 0) begin
                report_mismatch("unexpected transaction, status", res_if.status, 0);
            end else begin
                want = outcome_q.pop_front();
                if (res_if.status !== want.status)
                    report_mismatch("status", res_if.status, want.status);
                if (res_if.released_id !== want.rid)
                    report_mismatch("released_id", res_if.released_id, want.rid);
                if (res_if.released_class !== want.rcls)
                    report_mismatch("released_class", res_if.released_class, want.rcls);
                if (res_if.occupancy !== want.occ)
                    report_mismatch("occupancy", res_if.occupancy, want.occ);
            end
            n_checked++;
        end
    end

    // result receiver
    initial begin
        int rx_stall;
        rx_stall = 0;
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                // long hold-off: the block fills up and must stall its input
                hold_req = 1'b0;
                res_if.ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
            end else if (rx_eager) begin
                res_if.ready <= 1'b1;
            end else if (rx_stall > 0) begin
                res_if.ready <= 1'b0;
                rx_stall--;
            end else begin
                rx_stall = $urandom_range(0, 99);
                if (rx_stall < 70) begin
                    res_if.ready <= 1'b1;
                    rx_stall = 0;
                end else if (rx_stall < 95) begin
                    res_if.ready <= 1'b0;
                    rx_stall = $urandom_range(0, 2);
                end else begin
                    res_if.ready <= 1'b0;
                    rx_stall = $urandom_range(5, 30);
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("Timeout with %0d results still expected", outcome_q.size());
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int               k;
        int               r;
        int               burst;
        int               burst_len;
        int               rel_pct;
        int               sent;
        t_cmd             c;
        logic [CLS_W-1:0] cls;

        errors   = 0;
        n_cmds   = 0;
        n_checked = 0;
        n_ins_ok = 0;
        n_rel_ok = 0;
        peak_occ = 0;
        for (k = 0; k < 4; k++) status_tally[k] = 0;
        tx_eager = 1'b0;
        rx_eager = 1'b0;
        hold_req = 1'b0;

        i_rst_n              = 1'b0;
        cmd_if.valid         = 1'b0;
        cmd_if.cmd           = CMD_INSERT;
        cmd_if.vehicle_id    = '0;
        cmd_if.vehicle_class = CLS_NONE;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty release, bad class, extremes, fill to full, full rejects, then releases
        dir_rows.push_back('{CMD_RELEASE, 16'hFFFF, CLS_PRIVATE, 1, 1'b1,
                             '{ST_EMPTY, 16'h0, CLS_NONE, 5'd0}});
        dir_rows.push_back('{CMD_INSERT, 16'h0000, CLS_NONE, 1, 1'b1,
                             '{ST_BADCLASS, 16'h0, CLS_NONE, 5'd0}});
        dir_rows.push_back('{CMD_INSERT, 16'hFFFF, CLS_PRIVATE, 1, 1'b1,
                             '{ST_OK, 16'h0, CLS_NONE, 5'd1}});
        dir_rows.push_back('{CMD_INSERT, 16'h0000, CLS_PUBLIC, 1, 1'b0, NO_OUTCOME});
        dir_rows.push_back('{CMD_INSERT, 16'h8001, CLS_EMERG, 1, 1'b0, NO_OUTCOME});
        dir_rows.push_back('{CMD_INSERT, 16'h7FFE, CLS_PUBLIC, 1, 1'b0, NO_OUTCOME});
        dir_rows.push_back('{CMD_INSERT, 16'hAAAA, CLS_EMERG, 1, 1'b0, NO_OUTCOME});
        dir_rows.push_back('{CMD_INSERT, 16'h1000, CLS_PRIVATE, CAP - 5, 1'b0, NO_OUTCOME});
        dir_rows.push_back('{CMD_INSERT, 16'h2000, CLS_EMERG, 1, 1'b1,
                             '{ST_FULL, 16'h0, CLS_NONE, 5'd16}});
        dir_rows.push_back('{CMD_INSERT, 16'h2001, CLS_NONE, 1, 1'b1,
                             '{ST_BADCLASS, 16'h0, CLS_NONE, 5'd16}});
        dir_rows.push_back('{CMD_RELEASE, 16'h0000, CLS_NONE, 1, 1'b0, NO_OUTCOME});
        dir_rows.push_back('{CMD_INSERT, 16'h5555, CLS_EMERG, 1, 1'b0, NO_OUTCOME});
        dir_rows.push_back('{CMD_RELEASE, 16'h5A5A, CLS_PUBLIC, 3, 1'b0, NO_OUTCOME});

        for (r = 0; r < dir_rows.size(); r++) begin
            for (k = 0; k < dir_rows[r].reps; k++)
                issue(dir_rows[r].c, dir_rows[r].id + VID_W'(k), dir_rows[r].cls,
                      dir_rows[r].typed, dir_rows[r].want);
        end

        // sender pause until every result is back
        @(negedge i_clk);
        cmd_if.valid <= 1'b0;
        wait_drained();

        // random bursts that lean toward filling, draining or a mix
        sent  = 0;
        burst = 0;
        while (sent < RAND_ITEMS) begin
            burst_len = $urandom_range(10, 60);
            r = $urandom_range(0, 2);
            rel_pct = (r == 0) ? 15 : (r == 1) ? 85 : 50;
            tx_eager = ($urandom_range(0, 4) == 0);
            rx_eager = ($urandom_range(0, 4) == 0);
            if (burst == 1 || burst == 12) begin
                hold_req = 1'b1;
                tx_eager = 1'b1;
                rx_eager = 1'b0;
                rel_pct  = 20;
            end
            for (k = 0; k < burst_len; k++) begin
                c = ($urandom_range(0, 99) < rel_pct) ? CMD_RELEASE : CMD_INSERT;
                r = $urandom_range(0, 99);
                cls = (r < 6) ? CLS_NONE : CLS_W'($urandom_range(1, 3));
                issue(c, VID_W'($urandom), cls, 1'b0, NO_OUTCOME);
                sent++;
            end
            burst++;
            if (burst % 8 == 0) begin
                @(negedge i_clk);
                cmd_if.valid <= 1'b0;
                wait_drained();
            end
        end

        @(negedge i_clk);
        cmd_if.valid <= 1'b0;
        rx_eager = 1'b1;
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (outcome_q.size() != 0)
            report_mismatch("results never arrived, count", 0, outcome_q.size());

        $display("Ran %0d commands, %0d results checked: %0d inserts and %0d releases taken",
                 n_cmds, n_checked, n_ins_ok, n_rel_ok);
        $display("Rejected: %0d full, %0d empty release, %0d bad class; peak occupancy %0d",
                 status_tally[ST_FULL], status_tally[ST_EMPTY], status_tally[ST_BADCLASS],
                 peak_occ);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
